@@ hdl/rgsn_pkg.sv @@
// Package for the replay guard core: field widths, default parameters,
// verdict codes, controller states and the controller/datapath interface.
// No dependencies.
package rgsn_pkg;

    localparam int SEQ_W          = 64;
    localparam int EPOCH_W        = 32;
    localparam int NONCE_PORT_W   = 64;
    localparam int VERDICT_W      = 2;

    localparam int DEF_NONCE_WINDOW = 16;
    localparam int DEF_NONCE_BYTES  = 8;

    typedef enum logic [VERDICT_W-1:0] {
        V_ACCEPT = 2'd0,
        V_EPOCH  = 2'd1,
        V_OLD    = 2'd2,
        V_DUP    = 2'd3
    } t_verdict;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture the frame, clear the scan
        logic scan_en;  // issue one ring read
        logic commit;   // update floor, ring, head and fill count
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic epoch_bad;
        logic seq_old;
        logic empty;
        logic issued_all;
        logic scan_done;
        logic hit;
    } t_dp_stat;

endpackage

@@ hdl/rgsn_dp.sv @@
// Datapath of the replay guard: frame registers, epoch register, sequence
// floor, nonce ring memory with scan pipeline, head and fill count.
// Depends on rgsn_pkg.
module rgsn_dp import rgsn_pkg::*; #(
    parameter int NONCE_WINDOW = DEF_NONCE_WINDOW,
    parameter int NONCE_BYTES  = DEF_NONCE_BYTES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [SEQ_W-1:0]        i_frame_seq,
    input  logic [EPOCH_W-1:0]      i_frame_epoch,
    input  logic [NONCE_PORT_W-1:0] i_frame_nonce,
    input  logic                    i_cfg_valid,
    input  logic [EPOCH_W-1:0]      i_cfg_data,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat
);

    localparam int NONCE_W = 8 * NONCE_BYTES;
    localparam int IDX_W   = (NONCE_WINDOW > 1) ? $clog2(NONCE_WINDOW) : 1;
    localparam int CNT_W   = $clog2(NONCE_WINDOW + 1);

    logic [NONCE_W-1:0] r_mem [NONCE_WINDOW];

    logic [SEQ_W-1:0]   r_seq;
    logic [EPOCH_W-1:0] r_epoch;
    logic [NONCE_W-1:0] r_nonce;
    logic [EPOCH_W-1:0] r_cur_epoch;
    logic [SEQ_W-1:0]   r_floor;
    logic [IDX_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_fill;
    logic [IDX_W-1:0]   r_idx;
    logic [NONCE_W-1:0] r_rd_data;
    logic               r_rd_vld;
    logic               r_rd_last;
    logic               r_issued_all;
    logic               r_hit;

    logic               issue_last;
    logic               cmp_hit;

    assign issue_last = (CNT_W'(r_idx) == (r_fill - CNT_W'(1)));
    assign cmp_hit    = r_rd_vld && (r_rd_data == r_nonce);

    // Capture the frame; the nonce keeps only its meaningful bytes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_seq   <= i_frame_seq;
            r_epoch <= i_frame_epoch;
            r_nonce <= i_frame_nonce[NONCE_W-1:0];
        end
    end

    // Hold the boot epoch written over the config channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_epoch <= '0;
        end else if (i_cfg_valid) begin
            r_cur_epoch <= i_cfg_data;
        end
    end

    // Raise the floor, advance the head and count fills on an accepted frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= '0;
            r_head  <= '0;
            r_fill  <= '0;
        end else if (i_cmd.commit) begin
            r_floor <= r_seq;
            r_head  <= (r_head == IDX_W'(NONCE_WINDOW - 1)) ? '0 : r_head + IDX_W'(1);
            if (r_fill != CNT_W'(NONCE_WINDOW)) begin
                r_fill <= r_fill + CNT_W'(1);
            end
        end
    end

    // Ring memory: write at the head, registered read at the scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_mem[r_head] <= r_nonce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // Scan control: advance the index, track the last read and a sticky match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_rd_last    <= 1'b0;
            r_issued_all <= 1'b0;
            r_hit        <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_rd_last    <= 1'b0;
            r_issued_all <= 1'b0;
            r_hit        <= 1'b0;
        end else begin
            r_rd_vld  <= i_cmd.scan_en;
            r_rd_last <= i_cmd.scan_en && issue_last;
            if (i_cmd.scan_en) begin
                r_idx <= r_idx + IDX_W'(1);
                if (issue_last) begin
                    r_issued_all <= 1'b1;
                end
            end
            if (cmp_hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    // Report the checks
    always_comb begin
        o_stat.epoch_bad  = (r_epoch != r_cur_epoch);
        o_stat.seq_old    = (r_seq <= r_floor);
        o_stat.empty      = (r_fill == '0);
        o_stat.issued_all = r_issued_all;
        o_stat.scan_done  = r_rd_vld && r_rd_last;
        o_stat.hit        = r_hit || cmp_hit;
    end

endmodule

@@ hdl/rgsn_ctrl.sv @@
// Controller of the replay guard: sequences check, ring scan and commit,
// and registers the verdict strobe. Depends on rgsn_pkg.
module rgsn_ctrl import rgsn_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_done,
    output t_verdict o_verdict
);

    t_state   r_state, n_state;
    logic     r_done, n_done;
    t_verdict r_verdict, n_verdict;

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
    end

    // Next state, datapath commands and verdict
    always_comb begin
        n_state       = r_state;
        n_done        = 1'b0;
        n_verdict     = r_verdict;
        o_cmd.load    = 1'b0;
        o_cmd.scan_en = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.epoch_bad) begin
                    n_done    = 1'b1;
                    n_verdict = V_EPOCH;
                    n_state   = S_IDLE;
                end else if (i_stat.seq_old) begin
                    n_done    = 1'b1;
                    n_verdict = V_OLD;
                    n_state   = S_IDLE;
                end else if (i_stat.empty) begin
                    o_cmd.commit = 1'b1;
                    n_done       = 1'b1;
                    n_verdict    = V_ACCEPT;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.scan_en = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (i_stat.hit) begin
                        n_verdict = V_DUP;
                    end else begin
                        n_verdict    = V_ACCEPT;
                        o_cmd.commit = 1'b1;
                    end
                end else begin
                    o_cmd.scan_en = !i_stat.issued_all;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_verdict = r_verdict;

endmodule

@@ hdl/replay_guard_seq_nonce_core.sv @@
// Top level of the replay guard core: controller plus datapath.
// Depends on rgsn_pkg, rgsn_ctrl and rgsn_dp.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+------------------------------------
//  frame     | in        | start, busy           | i_frame_seq, i_frame_epoch, i_frame_nonce
//  verdict   | out       | o_done (1-cycle pulse)| o_verdict
//  config    | in        | i_cfg_valid, o_cfg_ready | i_cfg_data (current epoch)
//
// A frame is loaded and checked for epoch and sequence; when both checks pass and the
// ring is not empty, its filled entries are scanned before the verdict. The ring scan
// reads one entry per cycle from the ring memory over a single
// memory read port. busy is low again in the cycle the verdict shows, so the
// next frame can be taken then. Reset (synchronous, active low) clears the
// epoch, floor, head and fill count; ring contents are never cleared. The
// receiver cannot stall: each verdict is shown for exactly one cycle.
module replay_guard_seq_nonce_core import rgsn_pkg::*; #(
    parameter int NONCE_WINDOW = DEF_NONCE_WINDOW,
    parameter int NONCE_BYTES  = DEF_NONCE_BYTES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [SEQ_W-1:0]        i_frame_seq,
    input  logic [EPOCH_W-1:0]      i_frame_epoch,
    input  logic [NONCE_PORT_W-1:0] i_frame_nonce,
    output logic                    o_done,
    output logic [VERDICT_W-1:0]    o_verdict,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [EPOCH_W-1:0]      i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_verdict verdict;

    rgsn_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_verdict (verdict)
    );

    rgsn_dp #(
        .NONCE_WINDOW (NONCE_WINDOW),
        .NONCE_BYTES  (NONCE_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_seq   (i_frame_seq),
        .i_frame_epoch (i_frame_epoch),
        .i_frame_nonce (i_frame_nonce),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

    // Config is always taken; software must write it only while idle, which the block itself does not enforce
    assign o_cfg_ready = 1'b1;
    assign o_verdict   = verdict;

endmodule

@@ hdl/rgsn_chk.sv @@
// Port-level checker for the replay guard core and its bind.
// Depends on rgsn_pkg and replay_guard_seq_nonce_core.
module rgsn_chk import rgsn_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_done,
    input logic [VERDICT_W-1:0] o_verdict
);

    // Reset leaves the core idle with no verdict pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_done))
        else $error("core not idle after reset");

    // A transferred frame makes the core busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after frame transfer");

    // A verdict is shown only once the core is idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("verdict strobe while busy");

    // Verdict strobes never come in consecutive cycles
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("verdict strobe longer than one cycle");

    // A shown verdict carries known bits
    a_verdict_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown(o_verdict))
        else $error("verdict unknown while strobed");

endmodule

bind replay_guard_seq_nonce_core rgsn_chk u_rgsn_chk (.*);

@@ tb/replay_guard_seq_nonce_core_tb.sv @@
// Testbench for replay_guard_seq_nonce_core: epoch, sequence floor and nonce ring checks.
// Drives frames and epoch writes, predicts each verdict and compares it on every o_done.
// Depends on rgsn_pkg and replay_guard_seq_nonce_core.
module replay_guard_seq_nonce_core_tb;
    import rgsn_pkg::*;

    localparam int WINDOW      = DEF_NONCE_WINDOW;
    localparam int NBYTES      = DEF_NONCE_BYTES;
    localparam int STALL_LIMIT = 1000;
    localparam int HIST_DEPTH  = WINDOW + 8;
    localparam logic [NONCE_PORT_W-1:0] NONCE_MASK =
        {NONCE_PORT_W{1'b1}} >> (NONCE_PORT_W - 8 * NBYTES);
    localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [SEQ_W-1:0]        i_frame_seq;
    logic [EPOCH_W-1:0]      i_frame_epoch;
    logic [NONCE_PORT_W-1:0] i_frame_nonce;
    logic                    o_done;
    logic [VERDICT_W-1:0]    o_verdict;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [EPOCH_W-1:0]      i_cfg_data;

    // Guard state as the block should hold it
    logic [EPOCH_W-1:0]      exp_epoch;
    logic [SEQ_W-1:0]        exp_floor;
    logic [NONCE_PORT_W-1:0] exp_ring [WINDOW];
    int unsigned             ring_head;
    int unsigned             ring_fill;

    t_verdict                verdict_q [$];
    logic [NONCE_PORT_W-1:0] accepted_nonces [$];
    int unsigned             fail_count = 0;
    int unsigned             stall_cycles = 0;
    bit                      gaps_on = 1'b1;

    replay_guard_seq_nonce_core #(
        .NONCE_WINDOW (WINDOW),
        .NONCE_BYTES  (NBYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_frame_seq   (i_frame_seq),
        .i_frame_epoch (i_frame_epoch),
        .i_frame_nonce (i_frame_nonce),
        .o_done        (o_done),
        .o_verdict     (o_verdict),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Judge one frame against the guard state; commit it when accepted
    function automatic t_verdict judge_frame(input logic [SEQ_W-1:0] seq,
                                             input logic [EPOCH_W-1:0] epoch,
                                             input logic [NONCE_PORT_W-1:0] nonce);
        logic [NONCE_PORT_W-1:0] key;
        bit                      seen;
        key  = nonce & NONCE_MASK;
        seen = 1'b0;
        if (epoch != exp_epoch)
            return V_EPOCH;
        if (seq <= exp_floor)
            return V_OLD;
        for (int i = 0; i < WINDOW; i++)
            if (i < ring_fill && exp_ring[i] == key)
                seen = 1'b1;
        if (seen)
            return V_DUP;
        exp_floor           = seq;
        exp_ring[ring_head] = key;
        ring_head           = (ring_head + 1) % WINDOW;
        if (ring_fill < WINDOW)
            ring_fill++;
        return V_ACCEPT;
    endfunction

    // Offer one frame; hold start across back-to-back transfers. Entered at a falling edge.
    task automatic send_frame(input logic [SEQ_W-1:0] seq, input logic [EPOCH_W-1:0] epoch,
                              input logic [NONCE_PORT_W-1:0] nonce);
        t_verdict v;
        if (gaps_on && $urandom_range(0, 99) < 7) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_frame_seq   <= seq;
        i_frame_epoch <= epoch;
        i_frame_nonce <= nonce;
        do @(posedge i_clk); while (busy);
        v = judge_frame(seq, epoch, nonce);
        verdict_q.push_back(v);
        if (v == V_ACCEPT) begin
            accepted_nonces.push_back(nonce);
            if (accepted_nonces.size() > HIST_DEPTH)
                void'(accepted_nonces.pop_front());
        end
        @(negedge i_clk);
    endtask

    // Drop start and hold until every verdict is back
    task automatic drain_verdicts();
        start <= 1'b0;
        while (verdict_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Write the boot epoch while the block is idle
    task automatic write_epoch(input logic [EPOCH_W-1:0] value);
        drain_verdicts();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        exp_epoch = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Check every verdict against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected verdict, expected none, actual %0d",
                         $time, o_verdict);
                fail_count++;
            end else begin
                t_verdict exp_v;
                exp_v = verdict_q.pop_front();
                if (o_verdict !== exp_v) begin
                    $display("%0t: verdict mismatch, expected %0d, actual %0d",
                             $time, exp_v, o_verdict);
                    fail_count++;
                end
            end
        end
    end

    // Count cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // First frame, check order and basic duplicate handling at reset epoch
    task automatic test_first_frame_and_order();
        send_frame(64'd0, 32'd0, 64'd0);             // floor starts at zero
        send_frame(64'd0, 32'hFFFF_FFFF, 64'd0);     // epoch wins over sequence
        send_frame(64'd1, 32'd0, 64'd0);
        send_frame(64'd1, 32'd0, 64'd5);             // equal to floor
        send_frame(64'd2, 32'd0, 64'd0);             // duplicate nonce
        send_frame(64'd1, 32'd1, 64'd0);             // all three fail
        send_frame(64'd2, 32'd0, NONCE_MASK);
        send_frame(64'd3, 32'd0, NONCE_MASK);
        send_frame(64'd1, 32'd0, NONCE_MASK);        // stale and duplicate
        send_frame(64'd3, 32'd0, 64'd1);
    endtask

    // Epoch register at its top value
    task automatic test_epoch_register();
        write_epoch(32'hFFFF_FFFF);
        send_frame(64'd4, 32'd0, 64'd2);
        send_frame(64'd4, 32'hFFFF_FFFF, 64'd2);
        send_frame(64'd5, 32'hFFFF_FFFF, 64'd1);
        send_frame(64'd5, 32'h7FFF_FFFF, 64'd9);
    endtask

    // Mostly well-formed traffic with random content, plus stale, foreign and noise frames
    task automatic test_random_traffic();
        logic [EPOCH_W-1:0] phase_epoch [5];
        logic [SEQ_W-1:0]   seq;
        logic [SEQ_W-1:0]   back;
        logic [EPOCH_W-1:0] epoch;
        logic [NONCE_PORT_W-1:0] nonce;
        int unsigned        kind;
        phase_epoch[0] = 32'd0;
        phase_epoch[1] = $urandom;
        phase_epoch[2] = 32'h8000_0000;
        phase_epoch[3] = 32'hFFFF_FFFF;
        phase_epoch[4] = 32'd1;
        for (int p = 0; p < 5; p++) begin
            write_epoch(phase_epoch[p]);
            gaps_on = (p != 2);
            for (int n = 0; n < 250; n++) begin
                kind  = $urandom_range(0, 99);
                seq   = exp_floor + 64'd1 + $urandom_range(0, 999);
                epoch = exp_epoch;
                nonce = {$urandom, $urandom};
                if ($urandom_range(0, 99) < 5)
                    seq = exp_floor + {32'd0, $urandom} + 64'd1;
                if (accepted_nonces.size() != 0 && $urandom_range(0, 99) < 25)
                    nonce = accepted_nonces[$urandom_range(0, accepted_nonces.size() - 1)];
                if (kind >= 70 && kind < 80) begin
                    if ($urandom_range(0, 1))
                        epoch = exp_epoch ^ (32'd1 << $urandom_range(0, 31));
                    else
                        epoch = $urandom;
                end else if (kind >= 80 && kind < 90) begin
                    back = $urandom_range(0, 3000);
                    if (back > exp_floor)
                        back = exp_floor;
                    seq = exp_floor - back;
                end else if (kind >= 90) begin
                    seq   = {$urandom, $urandom};
                    epoch = $urandom;
                    nonce = {$urandom, $urandom};
                end
                // Occasionally let the block go fully idle before the next frame
                if ($urandom_range(0, 99) < 2)
                    drain_verdicts();
                send_frame(seq, epoch, nonce);
            end
        end
        gaps_on = 1'b1;
    endtask

    // Sequence at its top value; nothing can pass after it
    task automatic test_sequence_ceiling();
        send_frame(SEQ_MAX, exp_epoch, {$urandom, $urandom});
        send_frame(SEQ_MAX, exp_epoch, {$urandom, $urandom});
        send_frame(SEQ_MAX, ~exp_epoch, 64'd0);
        send_frame(64'd1, exp_epoch, NONCE_MASK);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_frame_seq   = '0;
        i_frame_epoch = '0;
        i_frame_nonce = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        exp_epoch     = '0;
        exp_floor     = '0;
        ring_head     = 0;
        ring_fill     = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_first_frame_and_order();
        test_epoch_register();
        test_random_traffic();
        test_sequence_ceiling();

        drain_verdicts();
        repeat (WINDOW + 4) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
